### rtl/hsu_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// hsu_pkg
// Shared constants and operation and status codes for the hash set unit.
// ============================================================================
package hsu_pkg;

    localparam int MAX_BUCKETS_DEF = 64;
    localparam int WAYS_DEF        = 8;
    localparam int KEY_WIDTH_DEF   = 32;

    localparam int CFG_W  = 7;
    localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

    localparam int IN_KEY_W   = 32;
    localparam int FUNC_W     = 2;
    localparam int STATUS_W   = 2;
    localparam int OUT_DATA_W = 8;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd2;

    localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

endpackage

### rtl/hash_set_insert_remove_lookup_unit.sv
`timescale 1ns / 1ps
// ============================================================================
// hash_set_insert_remove_lookup_unit
// Bucketed hash set with insert, remove and lookup; one status per request.
// ============================================================================
// After reset the unit sweeps its valid rows, one bucket per cycle, with
// s_axis_tready low; the bucket count register can be written during that
// time. The front modulo unit reduces each key by two bits per cycle and
// takes a new request only once the last one is pushed to the queue. The
// back part reads a whole bucket row, compares all ways in parallel and
// writes back, overlapping with the next key's modulo. Status: 0 done/found,
// 1 present/not found, 2 bucket full.
module hash_set_insert_remove_lookup_unit #(
    parameter int MAX_BUCKETS = hsu_pkg::MAX_BUCKETS_DEF,
    parameter int WAYS        = hsu_pkg::WAYS_DEF,
    parameter int KEY_WIDTH   = hsu_pkg::KEY_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [hsu_pkg::CFG_W-1:0]       i_cfg_wr_data,   // bucket_count
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [hsu_pkg::IN_KEY_W-1:0]    s_axis_tdata,    // key[31:0]
    input  logic [hsu_pkg::FUNC_W-1:0]      s_axis_tuser,    // func[1:0]
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [hsu_pkg::OUT_DATA_W-1:0]  m_axis_tdata     // status[1:0], zeros
);

    localparam int BW    = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam int REQ_W = BW + KEY_WIDTH + hsu_pkg::FUNC_W;

    logic                           clear_done;
    logic                           push, push_ready;
    logic [REQ_W-1:0]               req_in, req_out;
    logic                           req_valid, req_pop;
    logic [hsu_pkg::STATUS_W-1:0]   status;

    hsu_front #(
        .MAX_BUCKETS (MAX_BUCKETS),
        .KEY_WIDTH   (KEY_WIDTH),
        .BW          (BW),
        .REQ_W       (REQ_W)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_clear_done  (clear_done),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_key         (s_axis_tdata),
        .i_func        (s_axis_tuser),
        .o_push        (push),
        .i_push_ready  (push_ready),
        .o_req         (req_in)
    );

    hsu_queue #(
        .DATA_W (REQ_W)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_push_ready (push_ready),
        .i_data       (req_in),
        .o_valid      (req_valid),
        .i_pop        (req_pop),
        .o_data       (req_out)
    );

    hsu_back #(
        .MAX_BUCKETS (MAX_BUCKETS),
        .WAYS        (WAYS),
        .KEY_WIDTH   (KEY_WIDTH),
        .BW          (BW),
        .REQ_W       (REQ_W)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .o_clear_done (clear_done),
        .i_req_valid  (req_valid),
        .i_req        (req_out),
        .o_req_pop    (req_pop),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_status     (status)
    );

    assign m_axis_tdata = {{(hsu_pkg::OUT_DATA_W - hsu_pkg::STATUS_W){1'b0}}, status};

endmodule

### rtl/hsu_front.sv
`timescale 1ns / 1ps
// ============================================================================
// hsu_front
// Accepts requests, holds the bucket count register and reduces each key modulo
// it (0 read as 1, capped at MAX_BUCKETS), two quotient bits per cycle.
// ============================================================================
module hsu_front #(
    parameter int MAX_BUCKETS = hsu_pkg::MAX_BUCKETS_DEF,
    parameter int KEY_WIDTH   = hsu_pkg::KEY_WIDTH_DEF,
    parameter int BW          = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1,
    parameter int REQ_W       = BW + KEY_WIDTH + hsu_pkg::FUNC_W
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [hsu_pkg::CFG_W-1:0]   i_cfg_wr_data,
    input  logic                        i_clear_done,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [hsu_pkg::IN_KEY_W-1:0] i_key,
    input  logic [hsu_pkg::FUNC_W-1:0]  i_func,
    output logic                        o_push,
    input  logic                        i_push_ready,
    output logic [REQ_W-1:0]            o_req     // func, key, bucket from bit 0 up
);

    localparam int CW    = hsu_pkg::CFG_W;
    localparam int KP    = ((KEY_WIDTH + 1) / 2) * 2;
    localparam int STEPS = KP / 2;
    localparam int SCW   = $clog2(STEPS + 1);

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_DIV  = 3'b010,
        F_PUSH = 3'b100
    } t_fstate;

    t_fstate                     r_state, n_state;
    logic [CW-1:0]               r_bucket_count;
    logic [CW-1:0]               r_div, n_div;
    logic [CW-1:0]               r_rem, n_rem;
    logic [KP-1:0]               r_kshift, n_kshift;
    logic [KEY_WIDTH-1:0]        r_key, n_key;
    logic [hsu_pkg::FUNC_W-1:0]  r_func, n_func;
    logic [SCW-1:0]              r_step, n_step;

    logic [63:0]                 key_ext;
    logic [KEY_WIDTH-1:0]        key_m;
    logic [CW-1:0]               eff_div;
    logic [CW:0]                 t1, t2;
    logic [CW-1:0]               rem1, rem2;
    logic [31:0]                 rem_ext;
    logic                        accept;

    assign key_ext = 64'(i_key);
    assign key_m   = key_ext[KEY_WIDTH-1:0];

    always_comb begin
        if (r_bucket_count == '0) begin
            eff_div = CW'(1);
        end else if ({{(32-CW){1'b0}}, r_bucket_count} > 32'(MAX_BUCKETS)) begin
            eff_div = CW'(MAX_BUCKETS);
        end else begin
            eff_div = r_bucket_count;
        end
    end

    always_comb begin
        t1 = {r_rem, r_kshift[KP-1]};
        if (t1 >= {1'b0, r_div}) begin
            t1 = t1 - {1'b0, r_div};
        end
        rem1 = t1[CW-1:0];
        t2 = {rem1, r_kshift[KP-2]};
        if (t2 >= {1'b0, r_div}) begin
            t2 = t2 - {1'b0, r_div};
        end
        rem2 = t2[CW-1:0];
    end

    assign o_ready = (r_state == F_IDLE) && i_clear_done;
    assign accept  = o_ready && i_valid;
    assign o_push  = (r_state == F_PUSH);
    assign rem_ext = 32'(r_rem);
    assign o_req   = {rem_ext[BW-1:0], r_key, r_func};

    always_comb begin
        n_state  = r_state;
        n_div    = r_div;
        n_rem    = r_rem;
        n_kshift = r_kshift;
        n_key    = r_key;
        n_func   = r_func;
        n_step   = r_step;
        unique case (r_state)
            F_IDLE: begin
                if (accept) begin
                    n_div    = eff_div;
                    n_rem    = '0;
                    n_kshift = KP'(key_m);
                    n_key    = key_m;
                    n_func   = i_func;
                    n_step   = SCW'(STEPS);
                    n_state  = F_DIV;
                end
            end
            F_DIV: begin
                n_rem    = rem2;
                n_kshift = r_kshift << 2;
                n_step   = r_step - SCW'(1);
                if (r_step == SCW'(1)) begin
                    n_state = F_PUSH;
                end
            end
            F_PUSH: begin
                if (i_push_ready) begin
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= F_IDLE;
            r_bucket_count <= hsu_pkg::CFG_RESET;
            r_step         <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            if (i_cfg_wr_en) begin
                r_bucket_count <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_div    <= n_div;
        r_rem    <= n_rem;
        r_kshift <= n_kshift;
        r_key    <= n_key;
        r_func   <= n_func;
    end

endmodule

### rtl/hsu_queue.sv
`timescale 1ns / 1ps
// ============================================================================
// hsu_queue
// Short request queue between the front and back parts.
// ============================================================================
module hsu_queue #(
    parameter int DATA_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    output logic              o_push_ready,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_valid,
    input  logic              i_pop,
    output logic [DATA_W-1:0] o_data
);

    localparam int DEPTH = hsu_pkg::QUEUE_DEPTH;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW  = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [PW-1:0]     r_wr_ptr, r_rd_ptr;
    logic [CNTW-1:0]   r_count;
    logic              do_push, do_pop;

    assign o_push_ready = (r_count != CNTW'(DEPTH));
    assign o_valid      = (r_count != '0);
    assign o_data       = r_mem[r_rd_ptr];
    assign do_push      = i_push && o_push_ready;
    assign do_pop       = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNTW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNTW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

### rtl/hsu_back.sv
`timescale 1ns / 1ps
// ============================================================================
// hsu_back
// Holds the bucket memories, clears the valid rows after reset, and runs
// one request at a time: row read, way compare, update, status out.
// ============================================================================
module hsu_back #(
    parameter int MAX_BUCKETS = hsu_pkg::MAX_BUCKETS_DEF,
    parameter int WAYS        = hsu_pkg::WAYS_DEF,
    parameter int KEY_WIDTH   = hsu_pkg::KEY_WIDTH_DEF,
    parameter int BW          = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1,
    parameter int REQ_W       = BW + KEY_WIDTH + hsu_pkg::FUNC_W
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    output logic                          o_clear_done,
    input  logic                          i_req_valid,
    input  logic [REQ_W-1:0]              i_req,
    output logic                          o_req_pop,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [hsu_pkg::STATUS_W-1:0]  o_status
);

    localparam int FW = hsu_pkg::FUNC_W;
    localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int RW = WAYS * KEY_WIDTH;

    typedef enum logic [2:0] {
        B_CLEAR = 3'b001,
        B_IDLE  = 3'b010,
        B_EXEC  = 3'b100
    } t_bstate;

    logic [WAYS-1:0]             r_valid_mem [MAX_BUCKETS];
    logic [RW-1:0]               r_key_mem   [MAX_BUCKETS];

    t_bstate                     r_state, n_state;
    logic [BW-1:0]               r_clr_row;
    logic [WAYS-1:0]             r_vrow;
    logic [RW-1:0]               r_krow;
    logic [BW-1:0]               r_bucket;
    logic [KEY_WIDTH-1:0]        r_key;
    logic [FW-1:0]               r_func;
    logic                        r_out_valid;
    logic [hsu_pkg::STATUS_W-1:0] r_status;

    logic [BW-1:0]               q_bucket;
    logic [KEY_WIDTH-1:0]        q_key;
    logic [FW-1:0]               q_func;
    logic                        match_f, free_f;
    logic [WW-1:0]               match_w, free_w;
    logic [WAYS-1:0]             n_vrow;
    logic                        key_we;
    logic [hsu_pkg::STATUS_W-1:0] n_status;
    logic                        out_free, exec_go, pop;

    assign {q_bucket, q_key, q_func} = i_req;

    assign o_clear_done = (r_state != B_CLEAR);
    assign pop          = (r_state == B_IDLE) && i_req_valid;
    assign o_req_pop    = pop;
    assign out_free     = !r_out_valid || i_ready;
    assign exec_go      = (r_state == B_EXEC) && out_free;
    assign o_valid      = r_out_valid;
    assign o_status     = r_status;

    always_comb begin
        match_f = 1'b0;
        match_w = '0;
        free_f  = 1'b0;
        free_w  = '0;
        for (int w = 0; w < WAYS; w++) begin
            if (r_vrow[w]) begin
                if (!match_f && r_krow[w*KEY_WIDTH +: KEY_WIDTH] == r_key) begin
                    match_f = 1'b1;
                    match_w = WW'(w);
                end
            end else if (!free_f) begin
                free_f = 1'b1;
                free_w = WW'(w);
            end
        end
    end

    always_comb begin
        n_vrow   = r_vrow;
        key_we   = 1'b0;
        n_status = hsu_pkg::ST_MISS;
        priority if (r_func == hsu_pkg::FUNC_INSERT) begin
            if (match_f) begin
                n_status = hsu_pkg::ST_MISS;
            end else if (free_f) begin
                n_vrow[free_w] = 1'b1;
                key_we         = 1'b1;
                n_status       = hsu_pkg::ST_DONE;
            end else begin
                n_status = hsu_pkg::ST_FULL;
            end
        end else if (r_func == hsu_pkg::FUNC_REMOVE) begin
            if (match_f) begin
                n_vrow[match_w] = 1'b0;
                n_status        = hsu_pkg::ST_DONE;
            end else begin
                n_status = hsu_pkg::ST_MISS;
            end
        end else begin
            n_status = match_f ? hsu_pkg::ST_DONE : hsu_pkg::ST_MISS;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_CLEAR: begin
                if (r_clr_row == BW'(MAX_BUCKETS - 1)) begin
                    n_state = B_IDLE;
                end
            end
            B_IDLE: begin
                if (pop) begin
                    n_state = B_EXEC;
                end
            end
            B_EXEC: begin
                if (out_free) begin
                    n_state = B_IDLE;
                end
            end
            default: n_state = B_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_CLEAR;
            r_clr_row   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == B_CLEAR) begin
                r_clr_row <= r_clr_row + BW'(1);
            end
            if (exec_go) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec_go) begin
            r_status <= n_status;
        end
        if (pop) begin
            r_bucket <= q_bucket;
            r_key    <= q_key;
            r_func   <= q_func;
        end
    end

    // bucket memories
    always_ff @(posedge i_clk) begin
        if (r_state == B_CLEAR) begin
            r_valid_mem[r_clr_row] <= '0;
        end else if (exec_go) begin
            r_valid_mem[r_bucket] <= n_vrow;
        end
        if (exec_go && key_we) begin
            r_key_mem[r_bucket][free_w*KEY_WIDTH +: KEY_WIDTH] <= r_key;
        end
        if (pop) begin
            r_vrow <= r_valid_mem[q_bucket];
            r_krow <= r_key_mem[q_bucket];
        end
    end

endmodule
